[hdl/bba_pkg.sv]
// Shared types and constants for the buddy block allocator.
// No dependencies.
`default_nettype none
package bba_pkg;

	localparam int TREE_LEVELS = 8;
	localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
	localparam int IDX_W       = $clog2(NODE_COUNT + 1);
	localparam int LVL_W       = $clog2(TREE_LEVELS);
	localparam int CLVL_W      = LVL_W + 1;
	localparam int SEG_W       = 31;
	localparam int SIZE_W      = 40;
	localparam int OFF_W       = 37;
	localparam int FLAG_W      = 2;

	typedef enum logic [1:0] {
		STAT_GRANTED  = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_RELEASED = 2'd2
	} status_t;

	typedef struct packed {
		logic               kind;
		logic [SIZE_W-1:0]  request_size;
		logic [2:0]         release_level;
		logic [7:0]         release_node;
	} bba_in_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         node_index;
		logic [2:0]         block_level;
		logic [OFF_W-1:0]   byte_offset;
		logic               any_free;
	} bba_out_t;

	typedef struct packed {
		logic split;
		logic free;
	} flags_t;

	localparam flags_t FLAGS_INIT = '{split: 1'b0, free: 1'b1};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_SRCH_RD,
		ST_SRCH_EV,
		ST_SRCH_BT,
		ST_TAKE_RD,
		ST_TAKE_EV,
		ST_TAKE_PRD,
		ST_TAKE_PWR,
		ST_OFFSET,
		ST_REL_RD,
		ST_REL_WR,
		ST_REL_SRD,
		ST_REL_SEV,
		ST_REL_PRD,
		ST_REL_PWR,
		ST_ROOT_RD,
		ST_ROOT_EV,
		ST_DONE
	} bba_state_t;

	function automatic logic [IDX_W-1:0] buddy_of(input logic [IDX_W-1:0] idx);
		buddy_of = idx[0] ? IDX_W'(idx + 1'b1) : IDX_W'(idx - 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] idx);
		logic [IDX_W:0] up;
		up = ({1'b0, idx} + 1'b1) >> 1;
		parent_of = IDX_W'(up - 1'b1);
	endfunction

endpackage
`default_nettype wire

[hdl/bba_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 255
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/buddy_block_allocator.sv]
// Buddy allocator top level: sequencer over the node flag RAM.
// Depends on bba_pkg and bba_ram.
//
//  channel   direction  handshake            payload
//  in        into       in_valid / in_stall   bba_in_t  in_data
//  out       out of     out_valid / out_stall bba_out_t out_data
//  cfg       into       cfg_wr_en             segment_size cfg_wr_data
//
// One item at a time. Every node access is a RAM read then an evaluate state
// (one read port, one write port). Acquire: find the level, search the tree
// with backtracking, clear parents on the taken walk until a buddy check ends
// it, then compute the offset, read the root and present the result. Release:
// free the node, check its buddy and update the parent at each level below
// the root, then read the root; an out-of-range release reads only the root.
// Reset leaves every node free and unsplit at once through per-node valid bits.
// A result waiting on out_stall holds the sequencer in its last state.
`default_nettype none
module buddy_block_allocator (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire bba_pkg::bba_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output bba_pkg::bba_out_t      out_data,
	input  wire logic              cfg_wr_en,
	input  wire logic [30:0]       cfg_wr_data
);
	import bba_pkg::*;

	bba_state_t state_q, state_d;

	logic [SEG_W-1:0]  seg_q;
	logic [NODE_COUNT-1:0] valid_q;
	logic              out_valid_q;
	bba_out_t          out_q;

	logic [SIZE_W-1:0] size_q;
	logic [LVL_W-1:0]  tgt_q;
	logic [CLVL_W-1:0] clvl_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  wk_q;
	status_t           status_q;
	logic              own_split_q;
	logic              merge_q;
	logic              any_free_q;
	logic [38:0]       prod_q;
	logic [IDX_W-1:0]  rd_addr_s1;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	flags_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [FLAG_W-1:0] ram_rdata;
	flags_t            rd_flags;

	logic              acc;
	logic              rel_ok;
	logic              fit;
	logic [SIZE_W-1:0] seg_shift;
	logic              at_tgt;
	logic              out_free;
	logic [IDX_W-1:0]  child;
	logic [IDX_W-1:0]  first_idx;
	logic [IDX_W-1:0]  rel_idx;
	logic [45:0]       off_wide;

	bba_ram #(.WIDTH(FLAG_W), .DEPTH(NODE_COUNT)) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// nodes never written read as free, unsplit
	assign rd_flags  = valid_q[rd_addr_s1] ? flags_t'(ram_rdata) : FLAGS_INIT;
	assign acc       = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign rel_ok    = ({1'b0, in_data.release_level} < TREE_LEVELS) &&
		(in_data.release_node < NODE_COUNT);
	assign seg_shift = SIZE_W'(seg_q) << tgt_q;
	assign fit       = seg_shift >= size_q;
	assign at_tgt    = (clvl_q == CLVL_W'(tgt_q));
	assign child     = IDX_W'({cur_q, 1'b1});
	assign first_idx = IDX_W'((9'd1 << (LVL_W'(TREE_LEVELS - 1) - tgt_q)) - 9'd1);
	assign rel_idx   = cur_q - first_idx;
	assign off_wide  = 46'(prod_q) << tgt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_data.kind) state_d = rel_ok ? ST_REL_RD : ST_ROOT_RD;
					else state_d = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				if (fit) state_d = ST_SRCH_RD;
				else if (tgt_q == LVL_W'(TREE_LEVELS - 1)) state_d = ST_ROOT_RD;
			end
			ST_SRCH_RD: state_d = ST_SRCH_EV;
			ST_SRCH_EV: begin
				if (!rd_flags.free) state_d = ST_SRCH_BT;
				else if (!at_tgt) state_d = ST_SRCH_RD;
				else if (rd_flags.split) state_d = ST_SRCH_BT;
				else if (cur_q == '0) state_d = ST_OFFSET;
				else state_d = ST_TAKE_RD;
			end
			ST_SRCH_BT: begin
				if (cur_q == '0) state_d = ST_ROOT_RD;
				else if (cur_q[0]) state_d = ST_SRCH_RD;
			end
			ST_TAKE_RD: state_d = ST_TAKE_EV;
			ST_TAKE_EV: state_d = rd_flags.free ? ST_OFFSET : ST_TAKE_PRD;
			ST_TAKE_PRD: state_d = ST_TAKE_PWR;
			ST_TAKE_PWR: state_d = (parent_of(wk_q) == '0) ? ST_OFFSET : ST_TAKE_RD;
			ST_OFFSET: state_d = ST_ROOT_RD;
			ST_REL_RD: state_d = ST_REL_WR;
			ST_REL_WR: state_d = (wk_q == '0) ? ST_ROOT_RD : ST_REL_SRD;
			ST_REL_SRD: state_d = ST_REL_SEV;
			ST_REL_SEV: state_d = ST_REL_PRD;
			ST_REL_PRD: state_d = ST_REL_PWR;
			ST_REL_PWR: begin
				if (clvl_q + 1'b1 < TREE_LEVELS) state_d = ST_REL_RD;
				else state_d = ST_ROOT_RD;
			end
			ST_ROOT_RD: state_d = ST_ROOT_EV;
			ST_ROOT_EV: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = rd_flags;
		case (state_q)
			ST_SRCH_RD:  ram_raddr = cur_q;
			ST_SRCH_EV: begin
				if (rd_flags.free && !at_tgt) begin
					ram_we = 1'b1;
					ram_wdata.split = 1'b1;
				end else if (rd_flags.free && !rd_flags.split) begin
					ram_we = 1'b1;
					ram_wdata.free = 1'b0;
				end
			end
			ST_TAKE_RD:  ram_raddr = buddy_of(wk_q);
			ST_TAKE_PRD: ram_raddr = parent_of(wk_q);
			ST_TAKE_PWR: begin
				ram_we         = 1'b1;
				ram_waddr      = parent_of(wk_q);
				ram_wdata.free = 1'b0;
			end
			ST_REL_RD:   ram_raddr = wk_q;
			ST_REL_WR: begin
				ram_we         = 1'b1;
				ram_waddr      = wk_q;
				ram_wdata.free = 1'b1;
			end
			ST_REL_SRD:  ram_raddr = buddy_of(wk_q);
			ST_REL_PRD:  ram_raddr = parent_of(wk_q);
			ST_REL_PWR: begin
				ram_we          = 1'b1;
				ram_waddr       = parent_of(wk_q);
				ram_wdata.free  = 1'b1;
				ram_wdata.split = rd_flags.split && !merge_q;
			end
			default: ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_q       <= SEG_W'(4096);
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) seg_q <= cfg_wr_data;
			if (ram_we) valid_q[ram_waddr] <= 1'b1;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= ram_raddr;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					size_q   <= in_data.request_size;
					tgt_q    <= '0;
					cur_q    <= '0;
					wk_q     <= in_data.release_node;
					clvl_q   <= CLVL_W'(in_data.release_level);
					status_q <= in_data.kind ? STAT_RELEASED : STAT_GRANTED;
				end
			end
			ST_LEVEL: begin
				if (fit) begin
					clvl_q <= CLVL_W'(TREE_LEVELS - 1);
					cur_q  <= '0;
				end else if (tgt_q == LVL_W'(TREE_LEVELS - 1)) begin
					status_q <= STAT_NO_SPACE;
				end else begin
					tgt_q <= tgt_q + 1'b1;
				end
			end
			ST_SRCH_EV: begin
				if (rd_flags.free && !at_tgt) begin
					cur_q  <= child;
					clvl_q <= clvl_q - 1'b1;
				end else begin
					wk_q <= cur_q;
				end
			end
			// left child failed: try its buddy; right child failed: parent failed
			ST_SRCH_BT: begin
				if (cur_q == '0) begin
					status_q <= STAT_NO_SPACE;
				end else if (cur_q[0]) begin
					cur_q <= cur_q + 1'b1;
				end else begin
					cur_q  <= parent_of(cur_q);
					clvl_q <= clvl_q + 1'b1;
				end
			end
			ST_TAKE_PWR: wk_q <= parent_of(wk_q);
			ST_OFFSET:   prod_q <= 39'(rel_idx) * 39'(seg_q);
			ST_REL_WR:   own_split_q <= rd_flags.split;
			ST_REL_SEV:  merge_q <= rd_flags.free && !rd_flags.split && !own_split_q;
			ST_REL_PWR: begin
				wk_q   <= parent_of(wk_q);
				clvl_q <= clvl_q + 1'b1;
			end
			ST_ROOT_EV:  any_free_q <= rd_flags.free;
			ST_DONE: begin
				if (out_free) begin
					out_q.status   <= status_q;
					out_q.any_free <= any_free_q;
					if (status_q == STAT_GRANTED) begin
						out_q.node_index  <= cur_q;
						out_q.block_level <= tgt_q;
						out_q.byte_offset <= off_wide[OFF_W-1:0];
					end else begin
						out_q.node_index  <= '0;
						out_q.block_level <= '0;
						out_q.byte_offset <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != ST_IDLE)
		else $error("accepted transfer did not start the sequencer");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");

	a_search_above_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH_EV |-> clvl_q >= CLVL_W'(tgt_q))
		else $error("search descended below target level");

	a_write_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr < NODE_COUNT)
		else $error("flag write outside the tree");

endmodule
`default_nettype wire

[bench/buddy_block_allocator_check.sv]
// Checker for the buddy block allocator: tracks its own copy of the node flags,
// predicts each result from the input transfers and compares it with the output.
// Depends on bba_pkg.
`timescale 1ns / 1ps
module buddy_block_allocator_check (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire bba_pkg::bba_in_t  in_data,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire bba_pkg::bba_out_t out_data,
	input  wire logic              cfg_wr_en,
	input  wire logic [30:0]       cfg_wr_data,
	output int                     fail_count,
	output int                     pending,
	output int                     grant_count,
	output int                     release_count
);
	import bba_pkg::*;

	localparam int LEVELS = 8;
	localparam int NODES  = 255;

	bit        node_free [NODES];
	bit        node_split[NODES];
	bit [30:0] seg_bytes;
	bba_out_t  awaited[$];

	function automatic int buddy_idx(int idx);
		return (idx & 1) ? idx + 1 : idx - 1;
	endfunction

	function automatic int up_idx(int idx);
		return ((idx + 1) >> 1) - 1;
	endfunction

	function automatic bit find_block(int lvl, int tgt, int idx, ref int found);
		int child;
		if (idx >= NODES || !node_free[idx])
			return 0;
		if (lvl != tgt) begin
			if (lvl == 0)
				return 0;
			node_split[idx] = 1;
			child = 2 * idx + 1;
			if (find_block(lvl - 1, tgt, child, found))
				return 1;
			return find_block(lvl - 1, tgt, child + 1, found);
		end
		if (node_split[idx])
			return 0;
		node_free[idx] = 0;
		found = idx;
		return 1;
	endfunction

	function automatic bba_out_t allocate_or_free(bba_in_t it);
		bba_out_t r;
		int lvl, idx, found, par, sib, first;
		bit fits;
		logic [71:0] blk;
		r = '0;
		r.status = STAT_GRANTED;
		fits = 0;
		found = 0;
		if (!it.kind) begin
			for (lvl = 0; lvl < LEVELS; lvl++) begin
				blk = 72'(seg_bytes) << lvl;
				if (blk >= 72'(it.request_size)) begin
					fits = 1;
					break;
				end
			end
			if (fits && find_block(LEVELS - 1, lvl, 0, found)) begin
				idx = found;
				for (int l = lvl; l < LEVELS && idx != 0; l++) begin
					sib = buddy_idx(idx);
					if (node_free[idx] || node_free[sib])
						break;
					par = up_idx(idx);
					node_free[par] = 0;
					idx = par;
				end
				first = (1 << (LEVELS - lvl - 1)) - 1;
				r.node_index = 8'(found);
				r.block_level = 3'(lvl);
				r.byte_offset = 37'(72'(found - first) * (72'(seg_bytes) << lvl));
			end else begin
				r.status = STAT_NO_SPACE;
			end
		end else begin
			lvl = it.release_level;
			idx = it.release_node;
			if (lvl < LEVELS && idx < NODES) begin
				for (; lvl < LEVELS; lvl++) begin
					node_free[idx] = 1;
					if (idx == 0)
						break;
					sib = buddy_idx(idx);
					par = up_idx(idx);
					if (node_free[sib] && !node_split[sib] && !node_split[idx])
						node_split[par] = 0;
					node_free[par] = 1;
					idx = par;
				end
			end
			r.status = STAT_RELEASED;
		end
		r.any_free = node_free[0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bba_out_t exp_r;
		int errs;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				node_free[i] = 1;
				node_split[i] = 0;
			end
			seg_bytes = 31'd4096;
			awaited.delete();
			fail_count <= 0;
			pending <= 0;
			grant_count <= 0;
			release_count <= 0;
		end else begin
			errs = 0;
			if (cfg_wr_en)
				seg_bytes = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$error("result transfer with nothing expected");
					errs++;
				end else begin
					exp_r = awaited.pop_front();
					if (out_data.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, out_data.status);
						errs++;
					end
					if (out_data.node_index !== exp_r.node_index) begin
						$error("node_index: expected %0d, got %0d",
							exp_r.node_index, out_data.node_index);
						errs++;
					end
					if (out_data.block_level !== exp_r.block_level) begin
						$error("block_level: expected %0d, got %0d",
							exp_r.block_level, out_data.block_level);
						errs++;
					end
					if (out_data.byte_offset !== exp_r.byte_offset) begin
						$error("byte_offset: expected %0h, got %0h",
							exp_r.byte_offset, out_data.byte_offset);
						errs++;
					end
					if (out_data.any_free !== exp_r.any_free) begin
						$error("any_free: expected %0d, got %0d",
							exp_r.any_free, out_data.any_free);
						errs++;
					end
					if (exp_r.status == STAT_GRANTED)
						grant_count <= grant_count + 1;
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (in_valid && !in_stall) begin
				awaited.push_back(allocate_or_free(in_data));
				if (in_data.kind)
					release_count <= release_count + 1;
			end
			pending <= awaited.size();
		end
	end
endmodule

[bench/buddy_block_allocator_test.sv]
// Stimulus and verdict for the buddy block allocator: directed and random
// acquire/release transfers under varying idling. Depends on bba_pkg, the block
// and buddy_block_allocator_check.
`timescale 1ns / 1ps
module buddy_block_allocator_test;
	import bba_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic     clk = 0;
	logic     arst_n = 0;
	logic     in_valid = 0;
	logic     in_stall;
	bba_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 0;
	bba_out_t out_data;
	logic     cfg_wr_en = 0;
	logic [30:0] cfg_wr_data = '0;
	int       fail_count, pending, grant_count, release_count;
	int       send_idle_pct = 0, recv_idle_pct = 0;
	int       cycles = 0;

	// live blocks: node index and level, to build well-formed releases
	int       held_node[$];
	int       held_lvl[$];

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	buddy_block_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	buddy_block_allocator_check u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending),
		.grant_count(grant_count), .release_count(release_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("buddy_block_allocator_test: FAIL");
			$finish;
		end
	end

	// record grants so random releases can return real blocks
	always @(posedge clk) begin
		if (out_valid && !out_stall && out_data.status == STAT_GRANTED) begin
			held_node.push_back(out_data.node_index);
			held_lvl.push_back(out_data.block_level);
		end
	end

	task automatic send(bba_in_t it);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic acquire(logic [39:0] bytes);
		bba_in_t it;
		it = '0;
		it.request_size = bytes;
		send(it);
	endtask

	task automatic release_block(logic [2:0] lvl, logic [7:0] node);
		bba_in_t it;
		it = '0;
		it.kind = 1;
		it.release_level = lvl;
		it.release_node = node;
		it.request_size = {$urandom, $urandom};
		send(it);
	endtask

	task automatic drain();
		while (pending != 0 || in_valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_segment(logic [30:0] v);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic random_item();
		int k, pick;
		logic [39:0] sz;
		k = $urandom_range(99);
		if (k < 50) begin
			case ($urandom_range(3))
				0: sz = 40'($urandom_range(8)) * 40'(cfg_wr_data);
				1: sz = 40'($urandom_range(600000));
				2: sz = {$urandom, $urandom};
				default: sz = 40'(cfg_wr_data) << $urandom_range(7);
			endcase
			acquire(sz);
		end else if (k < 90 && held_node.size() != 0) begin
			pick = $urandom_range(held_node.size() - 1);
			release_block(3'(held_lvl[pick]), 8'(held_node[pick]));
			held_node.delete(pick);
			held_lvl.delete(pick);
		end else begin
			// stray release: random level and index, the index possibly out of range
			release_block(3'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		held_node.delete();
		held_lvl.delete();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		cfg_wr_data <= 31'd4096;
		@(posedge clk);

		// directed: extremes, exhaustion, frees, odd releases
		acquire(40'd0);
		acquire(40'd1);
		acquire(40'd4096);
		acquire(40'd4097);
		acquire(40'd4096 << 7);
		acquire((40'd4096 << 7) + 1);
		acquire(40'hFF_FFFF_FFFF);
		release_block(3'd7, 8'd0);
		acquire(40'd4096 << 7);
		acquire(40'd1);
		release_block(3'd7, 8'd0);
		repeat (4) acquire(40'd4096 << 6);
		release_block(3'd6, 8'd1);
		release_block(3'd6, 8'd2);
		release_block(3'd7, 8'd255);
		release_block(3'd7, 8'd254);
		release_block(3'd0, 8'd3);
		drain();
		held_node.delete();
		held_lvl.delete();
		release_block(3'd7, 8'd0);

		write_segment(31'd0);
		acquire(40'd0);
		acquire(40'd1);
		write_segment(31'h7FFF_FFFF);
		acquire(40'hFF_FFFF_FFFF);
		acquire(40'h7F_FFFF_FFFF);
		write_segment(31'd1);
		acquire(40'd128);
		acquire(40'd3);

		// random phases with idling profiles and segment settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 29; recv_idle_pct = 59; end
				1: begin send_idle_pct = 59; recv_idle_pct = 29; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (ph)
				0: write_segment(31'd4096);
				1: write_segment(31'd1);
				2: write_segment(31'd100);
				3: write_segment(31'($urandom));
				4: write_segment(31'h7FFF_FFFF);
				default: write_segment(31'd512);
			endcase
			for (int n = 0; n < 170; n++) begin
				random_item();
				if (n == 85)
					drain();
			end
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;
		drain();
		$display("covered %0d grants and %0d releases over six idling/segment phases",
			grant_count, release_count);
		if (fail_count == 0)
			$display("buddy_block_allocator_test: PASS");
		else
			$display("buddy_block_allocator_test: FAIL");
		$finish;
	end
endmodule
